FILE: design/positional_list_insert_delete_macros.svh
// Assertion macros shared by the positional list checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PLID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/plid_pkg.sv
// Shared types and codes for the positional list block.
// No dependencies; imported by every module of the block.
package plid_pkg;

	localparam int OPCODE_W   = 3;
	localparam int POSITION_W = 5;
	localparam int PAYLOAD_W  = 32;
	localparam int COUNT_W    = 5;
	localparam int STATUS_W   = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_POP    = 3'd3,
		OP_READ   = 3'd4
	} plid_op_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} plid_status_e;

	typedef struct packed {
		logic [OPCODE_W-1:0]   opcode;
		logic [POSITION_W-1:0] position;
		logic [PAYLOAD_W-1:0]  entry_in;
	} plid_req_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] entry_out;
		logic [COUNT_W-1:0]   entry_count;
		plid_status_e         status;
	} plid_rsp_t;

	// Broadcast to every cell for one cycle
	typedef struct packed {
		logic ins;
		logic del;
	} plid_cmd_t;

endpackage

FILE: design/positional_list_insert_delete.sv
// Positional list: bounded ordered list built as a chain of shifting cells.
// Depends on plid_pkg and plid_cell.
//
//   channel   direction   handshake                payload
//   req       in          req_valid / req_ready    plid_req_t (opcode, position, entry_in)
//   rsp       out         rsp_valid / rsp_ready    plid_rsp_t (entry_out, entry_count, status)
//
// All cells shift together at the accepting edge, and the result is captured in the
// output register at that same edge.
// A new transaction is taken whenever the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents are left as they are.
// A stall on rsp holds the result and blocks req until it is taken.
module positional_list_insert_delete #(
	parameter int DEPTH       = 16,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  plid_pkg::plid_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output plid_pkg::plid_rsp_t rsp
);
	import plid_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic [PW-1:0]          pos_w;
	logic [PW-1:0]          cnt_w;
	logic                   full;
	logic                   empty;
	logic                   pos_ok;
	logic                   accept;
	logic                   take;
	plid_status_e           status;
	plid_cmd_t              cmd_raw;
	plid_cmd_t              cmd;
	logic [IW-1:0]          idx;
	logic [ENTRY_WIDTH-1:0] wr_data;
	logic [ENTRY_WIDTH-1:0] rd_data;
	logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
	logic [ENTRY_WIDTH-1:0] cell_hit  [DEPTH];
	logic                   rsp_valid_q;
	plid_rsp_t              rsp_q;

	assign accept  = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign wr_data = ENTRY_WIDTH'(req.entry_in);

	// Range checks on the current count
	assign pos_w  = PW'(req.position);
	assign cnt_w  = PW'(count_q);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

	// Decode the operation into a cell command, new count and status
	always_comb begin
		cmd_raw = '0;
		idx     = IW'(pos_w - PW'(1));
		status  = ST_OK;
		take    = 1'b0;
		count_d = count_q;
		unique case (req.opcode)
			OP_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd_raw.ins = 1'b1;
					idx         = IW'(count_q);
					count_d     = count_q + CW'(1);
				end
			end
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (!pos_ok) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.ins = 1'b1;
					count_d     = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!pos_ok) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.del = 1'b1;
					count_d     = count_q - CW'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd_raw.del = 1'b1;
					idx         = '0;
					take        = 1'b1;
					count_d     = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!pos_ok) begin
					status = ST_RANGE;
				end else begin
					take = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Only move the chain on an accepted transaction
	assign cmd = accept ? cmd_raw : '0;

	// Chain of cells, each linked to its neighbours
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left;
		logic [ENTRY_WIDTH-1:0] right;
		if (k == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[k+1];
		end
		plid_cell #(
			.ENTRY_WIDTH (ENTRY_WIDTH),
			.INDEX_W     (IW),
			.INDEX       (k)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (idx),
			.wr_data (wr_data),
			.left    (left),
			.right   (right),
			.data    (cell_data[k]),
			.hit     (cell_hit[k])
		);
	end

	// Merge the addressed cell onto the read bus
	always_comb begin
		rd_data = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_data = rd_data | cell_hit[k];
		end
	end

	// Hold the count and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.entry_out   <= take ? PAYLOAD_W'(rd_data) : '0;
			rsp_q.entry_count <= COUNT_W'(count_d);
			rsp_q.status      <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: design/plid_cell.sv
// One storage cell of the list chain: holds the entry at a fixed index.
// Depends on plid_pkg for the broadcast command type.
module plid_cell #(
	parameter int ENTRY_WIDTH = 32,
	parameter int INDEX_W     = 4,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  plid_pkg::plid_cmd_t    cmd,
	input  logic [INDEX_W-1:0]     idx,
	input  logic [ENTRY_WIDTH-1:0] wr_data,
	input  logic [ENTRY_WIDTH-1:0] left,
	input  logic [ENTRY_WIDTH-1:0] right,
	output logic [ENTRY_WIDTH-1:0] data,
	output logic [ENTRY_WIDTH-1:0] hit
);
	import plid_pkg::*;

	localparam logic [INDEX_W-1:0] K = INDEX_W'(INDEX);

	logic [ENTRY_WIDTH-1:0] data_q;

	// Take the new entry, shift up from the lower neighbour or down from the upper one
	always_ff @(posedge clk) begin
		priority if (cmd.ins && idx == K) begin
			data_q <= wr_data;
		end else if (cmd.ins && K > idx) begin
			data_q <= left;
		end else if (cmd.del && K >= idx) begin
			data_q <= right;
		end else begin
			data_q <= data_q;
		end
	end

	// Drive the read bus only when this cell is addressed
	assign data = data_q;
	assign hit  = (idx == K) ? data_q : '0;

endmodule

FILE: design/plid_checker.sv
// Port-level checks for the positional list, bound to the top level.
// Depends on plid_pkg and positional_list_insert_delete_macros.svh.
`include "positional_list_insert_delete_macros.svh"

module plid_checker #(
	parameter int DEPTH = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input plid_pkg::plid_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input plid_pkg::plid_rsp_t rsp
);
	import plid_pkg::*;

	// Hold a stalled result
	`PLID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

	// Drop the payload on any failed transaction
	`PLID_ASSERT_NOW(a_fail_zero, rsp_valid && rsp.status != ST_OK, rsp.entry_out == '0, "failed transaction returned an entry")

	// An empty report comes only with no entries held
	`PLID_ASSERT_NOW(a_empty_cnt, rsp_valid && rsp.status == ST_EMPTY, rsp.entry_count == '0, "empty status with entries held")

	// A full report comes only with every cell in use
	`PLID_ASSERT_NOW(a_full_cnt, rsp_valid && rsp.status == ST_FULL, DEPTH > 31 || rsp.entry_count == DEPTH, "full status below capacity")

	// The count never passes the capacity
	`PLID_ASSERT_NOW(a_cnt_cap, rsp_valid, DEPTH > 31 || rsp.entry_count <= DEPTH, "entry count above capacity")

endmodule

bind positional_list_insert_delete plid_checker #(.DEPTH(DEPTH)) u_plid_checker (.*);
